### rtl/core/pca2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_pkg
// Types, widths and helpers shared by the 2D principal direction block.
// ----------------------------------------------------------------------------
package pca2d_pkg;

   localparam int COORD_BITS = 18;
   localparam int DX_BITS    = COORD_BITS + 1;
   localparam int CNT_BITS   = 11;
   localparam int MAX_POINTS = 1024;
   localparam int COUNT_TOP  = (1 << CNT_BITS) - 1;
   localparam int POINT_CAP  = (MAX_POINTS < COUNT_TOP) ? MAX_POINTS : COUNT_TOP;
   localparam int SUM_BITS   = 29;
   localparam int SQ_BITS    = 47;
   localparam int OUT_BITS   = 48;
   localparam int WORD_BITS  = 64;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int STEP_BITS  = 6;
   localparam int REM_BITS   = WORD_BITS + 3;

   localparam logic signed [WORD_BITS-1:0] OUT_MAX =
      (WORD_BITS'(1) <<< (OUT_BITS - 1)) - WORD_BITS'(1);
   localparam logic signed [WORD_BITS-1:0] OUT_MIN = -OUT_MAX - WORD_BITS'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_MUL_GO,
      S_MUL_WAIT,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_OUT
   } state_type;

   // product steps of the final eigen computation, in issue order
   typedef enum logic [3:0] {
      MS_NSQX,
      MS_SXSX,
      MS_NSQY,
      MS_SYSY,
      MS_NCR,
      MS_SXSY,
      MS_ADAD,
      MS_BB,
      MS_DOTX,
      MS_DOTY
   } mul_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        accum;
      logic        mul_start;
      logic        mul_store;
      mul_sel_type mul_sel;
      logic        sqrt_start;
      logic        sqrt_store;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic req_fire;
      logic last;
      logic few;
      logic mul_done;
      logic sqrt_done;
      logic rsp_free;
   } status_type;

   function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
   endfunction

   function automatic logic signed [OUT_BITS-1:0] sat_out(
      input logic signed [WORD_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] c;
      c = v;
      if (v > OUT_MAX) c = OUT_MAX;
      if (v < OUT_MIN) c = OUT_MIN;
      return c[OUT_BITS-1:0];
   endfunction

endpackage

### rtl/core/pca2d_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_req_if
// Point channel: coordinates, centre and set markers.
// ----------------------------------------------------------------------------
interface pca2d_req_if import pca2d_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic                         first_point;
   logic                         last_point;

   modport source (output valid, point_x, point_y, center_x, center_y, first_point,
                   last_point, input ready);
   modport sink (input valid, point_x, point_y, center_x, center_y, first_point,
                 last_point, output ready);
endinterface

### rtl/core/pca2d_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_rsp_if
// Result channel: principal direction and validity flag.
// ----------------------------------------------------------------------------
interface pca2d_rsp_if import pca2d_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] dir_x;
   logic signed [OUT_BITS-1:0] dir_y;
   logic                       valid_res;

   modport source (output valid, dir_x, dir_y, valid_res, input ready);
   modport sink (input valid, dir_x, dir_y, valid_res, output ready);
endinterface

### rtl/core/pca2d_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_mul
// Shift-add multiplier, 64 x 64 unsigned, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pca2d_mul import pca2d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   output logic                 done,
   output logic [PROD_BITS-1:0] product
);
   logic [PROD_BITS-1:0] acc_ff, mcand_ff;
   logic [WORD_BITS-1:0] mplier_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_BITS'(1);
            if (cnt_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= PROD_BITS'(op_a);
         mplier_ff <= op_b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

### rtl/core/pca2d_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_sqrt
// Restoring integer square root of a 128-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module pca2d_sqrt import pca2d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] radicand,
   output logic                 done,
   output logic [WORD_BITS-1:0] root
);
   logic [PROD_BITS-1:0] rad_ff;
   logic [REM_BITS-1:0]  rem_ff, rem_t, trial;
   logic [WORD_BITS-1:0] root_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   assign rem_t = {rem_ff[REM_BITS-3:0], rad_ff[PROD_BITS-1:PROD_BITS-2]};
   assign trial = REM_BITS'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_BITS'(1);
            if (cnt_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= rad_ff << 2;
         if (rem_t >= trial) begin
            rem_ff  <= rem_t - trial;
            root_ff <= {root_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_t;
            root_ff <= {root_ff[WORD_BITS-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

### rtl/core/pca2d_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_datapath
// Point accumulators, scatter matrix, eigenvector and result register.
// ----------------------------------------------------------------------------
module pca2d_datapath import pca2d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   pca2d_req_if.sink         req,
   pca2d_rsp_if.source       rsp
);
   logic signed [COORD_BITS-1:0] center_x_ff, center_y_ff, cx_sel, cy_sel;
   logic [CNT_BITS-1:0]          count_ff, cnt_base;
   logic signed [SUM_BITS-1:0]   sum_x_ff, sum_y_ff;
   logic [SQ_BITS-1:0]           sq_x_ff, sq_y_ff;
   logic signed [SQ_BITS-1:0]    cross_ff;
   logic signed [DX_BITS-1:0]    dx_ff, dy_ff;
   logic                         take_ff, last_ff, take, req_fire;
   logic signed [2*DX_BITS-1:0]  pxx, pyy, pxy;

   logic signed [WORD_BITS-1:0] a_ff, d_ff, b_ff, p1_ff, vy_ff;
   logic signed [WORD_BITS-1:0] sx64, sy64, fx, fy;
   logic [PROD_BITS-1:0]        s_ff, prod;
   logic signed [PROD_BITS-1:0] dot_ff, sprod;
   logic [WORD_BITS-1:0]        mul_a, mul_b, root;
   logic                        mul_neg, mul_done, sqrt_done, few;
   logic signed [WORD_BITS+1:0] vy_sum;

   logic                       rsp_valid_ff, rsp_res_ff;
   logic signed [OUT_BITS-1:0] rsp_x_ff, rsp_y_ff;

   assign req_fire = req.valid & cmd.req_ready;
   assign req.ready = cmd.req_ready;

   // the first point of a set already measures against its own centre
   assign cx_sel   = req.first_point ? req.center_x : center_x_ff;
   assign cy_sel   = req.first_point ? req.center_y : center_y_ff;
   assign cnt_base = req.first_point ? '0 : count_ff;
   assign take     = cnt_base < CNT_BITS'(POINT_CAP);

   assign pxx = dx_ff * dx_ff;
   assign pyy = dy_ff * dy_ff;
   assign pxy = dx_ff * dy_ff;
   assign few = count_ff < CNT_BITS'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         count_ff    <= '0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sq_x_ff     <= '0;
         sq_y_ff     <= '0;
         cross_ff    <= '0;
         take_ff     <= 1'b0;
         last_ff     <= 1'b0;
      end else if (req_fire) begin
         if (req.first_point) begin
            center_x_ff <= req.center_x;
            center_y_ff <= req.center_y;
            sum_x_ff    <= '0;
            sum_y_ff    <= '0;
            sq_x_ff     <= '0;
            sq_y_ff     <= '0;
            cross_ff    <= '0;
         end
         count_ff <= cnt_base + CNT_BITS'(take);
         take_ff  <= take;
         last_ff  <= req.last_point;
      end else if (cmd.accum) begin
         if (take_ff) begin
            sum_x_ff <= sum_x_ff + SUM_BITS'(dx_ff);
            sum_y_ff <= sum_y_ff + SUM_BITS'(dy_ff);
            sq_x_ff  <= sq_x_ff + SQ_BITS'(pxx);
            sq_y_ff  <= sq_y_ff + SQ_BITS'(pyy);
            cross_ff <= cross_ff + SQ_BITS'(pxy);
         end
      end else if (cmd.rsp_load) begin
         // drop the set, keep the centre for points without a first marker
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sq_x_ff  <= '0;
         sq_y_ff  <= '0;
         cross_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dx_ff <= DX_BITS'(req.point_x) - DX_BITS'(cx_sel);
         dy_ff <= DX_BITS'(req.point_y) - DX_BITS'(cy_sel);
      end
   end

   assign sx64 = WORD_BITS'(sum_x_ff);
   assign sy64 = WORD_BITS'(sum_y_ff);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      unique case (cmd.mul_sel)
         MS_NSQX: begin
            mul_a = WORD_BITS'(count_ff);
            mul_b = WORD_BITS'(sq_x_ff);
         end
         MS_SXSX: begin
            mul_a = mag(sx64);
            mul_b = mag(sx64);
         end
         MS_NSQY: begin
            mul_a = WORD_BITS'(count_ff);
            mul_b = WORD_BITS'(sq_y_ff);
         end
         MS_SYSY: begin
            mul_a = mag(sy64);
            mul_b = mag(sy64);
         end
         MS_NCR: begin
            mul_a   = WORD_BITS'(count_ff);
            mul_b   = mag(WORD_BITS'(cross_ff));
            mul_neg = cross_ff[SQ_BITS-1];
         end
         MS_SXSY: begin
            mul_a   = mag(sx64);
            mul_b   = mag(sy64);
            mul_neg = sx64[WORD_BITS-1] ^ sy64[WORD_BITS-1];
         end
         MS_ADAD: begin
            mul_a = mag(a_ff - d_ff);
            mul_b = mag(a_ff - d_ff);
         end
         MS_BB: begin
            mul_a = mag(b_ff) << 1;
            mul_b = mag(b_ff) << 1;
         end
         MS_DOTX: begin
            mul_a   = mag(sx64);
            mul_b   = mag(b_ff);
            mul_neg = sx64[WORD_BITS-1] ^ b_ff[WORD_BITS-1];
         end
         MS_DOTY: begin
            mul_a   = mag(sy64);
            mul_b   = mag(vy_ff);
            mul_neg = sy64[WORD_BITS-1] ^ vy_ff[WORD_BITS-1];
         end
         default: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   pca2d_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   pca2d_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (s_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   assign sprod  = mul_neg ? -signed'(prod) : signed'(prod);
   // d - a + r is never negative, so the halving is a plain shift
   assign vy_sum = (WORD_BITS+2)'(d_ff) - (WORD_BITS+2)'(a_ff)
                 + signed'((WORD_BITS+2)'(root));

   always_ff @(posedge clock) begin
      if (cmd.mul_store) begin
         unique case (cmd.mul_sel)
            MS_NSQX, MS_NSQY, MS_NCR: p1_ff <= sprod[WORD_BITS-1:0];
            MS_SXSX: a_ff <= p1_ff - sprod[WORD_BITS-1:0];
            MS_SYSY: d_ff <= p1_ff - sprod[WORD_BITS-1:0];
            MS_SXSY: b_ff <= p1_ff - sprod[WORD_BITS-1:0];
            MS_ADAD: s_ff <= prod;
            MS_BB:   s_ff <= s_ff + prod;
            MS_DOTX: dot_ff <= sprod;
            MS_DOTY: dot_ff <= dot_ff + sprod;
            default: p1_ff <= p1_ff;
         endcase
      end
      if (cmd.sqrt_store) vy_ff <= vy_sum[WORD_BITS:1];
   end

   // flip only when the direction points against the mean offset
   assign fx = dot_ff[PROD_BITS-1] ? -b_ff : b_ff;
   assign fy = dot_ff[PROD_BITS-1] ? -vy_ff : vy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_x_ff   <= few ? '0 : sat_out(fx);
         rsp_y_ff   <= few ? '0 : sat_out(fy);
         rsp_res_ff <= ~few;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.dir_x     = rsp_x_ff;
   assign rsp.dir_y     = rsp_y_ff;
   assign rsp.valid_res = rsp_res_ff;

   assign status.req_fire  = req_fire;
   assign status.last      = last_ff;
   assign status.few       = few;
   assign status.mul_done  = mul_done;
   assign status.sqrt_done = sqrt_done;
   assign status.rsp_free  = ~rsp_valid_ff | rsp.ready;
endmodule

### rtl/core/pca2d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_ctrl
// Sequencer: point intake, product steps, square root and result hand-off.
// ----------------------------------------------------------------------------
module pca2d_ctrl import pca2d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);
   state_type   state_ff, state_in;
   mul_sel_type sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= MS_NSQX;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         S_IDLE: if (status.req_fire) state_in = S_ACC;
         S_ACC: begin
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (status.few) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL_GO;
               sel_in   = MS_NSQX;
            end
         end
         S_MUL_GO: state_in = S_MUL_WAIT;
         S_MUL_WAIT: begin
            if (status.mul_done) begin
               priority if (sel_ff == MS_BB) begin
                  state_in = S_SQRT_GO;
               end else if (sel_ff == MS_DOTY) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_MUL_GO;
                  sel_in   = mul_sel_type'(sel_ff + 4'd1);
               end
            end
         end
         S_SQRT_GO: state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               state_in = S_MUL_GO;
               sel_in   = MS_DOTX;
            end
         end
         S_OUT: if (status.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.mul_sel    = sel_ff;
      unique case (state_ff)
         S_IDLE:      cmd.req_ready  = 1'b1;
         S_ACC:       cmd.accum      = 1'b1;
         S_MUL_GO:    cmd.mul_start  = 1'b1;
         S_MUL_WAIT:  cmd.mul_store  = status.mul_done;
         S_SQRT_GO:   cmd.sqrt_start = 1'b1;
         S_SQRT_WAIT: cmd.sqrt_store = status.sqrt_done;
         S_OUT:       cmd.rsp_load   = status.rsp_free;
         default:     cmd.req_ready  = 1'b0;
      endcase
   end
endmodule

### rtl/core/pca_direction_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_direction_2d_top
// Principal direction of a set of 2D points.
// ----------------------------------------------------------------------------
// For each point the block first takes the item and forms its offsets from
// the centre, then adds the offset, squares and cross product into the sums.
// After a point without last_point the block returns to idle and takes the
// next one. On the last point of a set with two or more points a shared
// shift-add multiplier runs ten 64-bit products and a two-bit-a-cycle square
// root unit runs once; a set with fewer than two points goes straight from the
// summing step to the result with valid_res low. The result waits in an output
// register while the block goes on taking the points of the next set; input
// stalls in the summing step, while the products and square root run, and when
// the next result is ready and that register still holds an unaccepted item.
// ----------------------------------------------------------------------------
module pca_direction_2d_top import pca2d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   pca2d_req_if.sink    req_ch,
   pca2d_rsp_if.source  rsp_ch
);
   cmd_type    cmd;
   status_type status;

   pca2d_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   pca2d_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req_ch),
      .rsp    (rsp_ch)
   );
endmodule

### rtl/core/pca2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca2d_checker
// Port-level checks for the principal direction block.
// ----------------------------------------------------------------------------
module pca2d_checker import pca2d_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_dir_x,
   input logic signed [OUT_BITS-1:0] rsp_dir_y,
   input logic                       rsp_valid_res
);
   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // an invalid set carries a zero direction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_dir_x == '0 && rsp_dir_y == '0)
      else $error("invalid result with nonzero direction");

   // the point just taken is summed before the next one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken back to back");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");
endmodule

bind pca_direction_2d_top pca2d_checker u_pca2d_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_dir_x     (rsp_ch.dir_x),
   .rsp_dir_y     (rsp_ch.dir_y),
   .rsp_valid_res (rsp_ch.valid_res)
);

### verif/pca_direction_2d_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_direction_2d_top_test
// Self-checking bench for the 2D principal direction block: directed and
// random point sets with random idling on both sides, results checked field
// by field against an exact integer predictor of the scatter-matrix eigenvector.
// ----------------------------------------------------------------------------
module pca_direction_2d_top_test;
   import pca2d_pkg::*;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic                         first;
      logic                         last;
   } point_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] dx;
      logic signed [OUT_BITS-1:0] dy;
      logic                       ok;
   } dir_type;

   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;

   pca2d_req_if req_ch ();
   pca2d_rsp_if rsp_ch ();

   pca_direction_2d_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   point_type pending_points[$];
   dir_type   expected_dirs[$];
   int     error_count;
   int     idle_cycles;
   bit     stim_done;
   int     send_gap;
   int     recv_gap;
   int     hold_off;
   int     rsp_seen;
   bit     hold_used;

   // predictor state
   int unsigned              pt_count;
   logic signed [18:0]       ctr_x, ctr_y;
   logic signed [SUM_BITS-1:0] sum_x, sum_y;
   logic [SQ_BITS-1:0]       sq_x, sq_y;
   logic signed [SQ_BITS-1:0] cr_sum;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [OUT_BITS-1:0] clip48(input logic signed [127:0] v);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (OUT_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[OUT_BITS-1:0];
      if (v < lo) return lo[OUT_BITS-1:0];
      return v[OUT_BITS-1:0];
   endfunction

   function automatic logic [127:0] root_floor(input logic [127:0] v);
      logic [127:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   task automatic append_point(input point_type p);
      pending_points.insert(pending_points.size(), p);
   endtask

   task automatic predict_direction(input point_type p);
      logic signed [127:0] ddx, ddy, n, sx, sy, a, d, b, vx, vy, dot, ad;
      logic [127:0] mx, my, disc, r;
      dir_type e;
      if (p.first) begin
         pt_count = 0; sum_x = '0; sum_y = '0; sq_x = '0; sq_y = '0; cr_sum = '0;
         ctr_x = p.cx; ctr_y = p.cy;
      end
      if (pt_count < POINT_CAP) begin
         ddx = p.px - ctr_x;
         ddy = p.py - ctr_y;
         sum_x += ddx[SUM_BITS-1:0];
         sum_y += ddy[SUM_BITS-1:0];
         sq_x += SQ_BITS'(ddx * ddx);
         sq_y += SQ_BITS'(ddy * ddy);
         cr_sum += SQ_BITS'(ddx * ddy);
         pt_count++;
      end
      if (!p.last) return;
      e = '0;
      if (pt_count >= 2) begin
         n = pt_count;
         sx = sum_x; sy = sum_y;
         a = n * $signed({81'd0, sq_x}) - sx * sx;
         d = n * $signed({81'd0, sq_y}) - sy * sy;
         b = n * cr_sum - sx * sy;
         // 64-bit wrap, as the datapath words are 64 bits
         a = $signed(a[63:0]); d = $signed(d[63:0]); b = $signed(b[63:0]);
         ad = a - d;
         mx = ad < 0 ? -ad : ad; mx = mx[63:0];
         my = b < 0 ? -b : b; my = {my[62:0], 1'b0}; my = my[63:0];
         disc = mx * mx + my * my;
         r = root_floor(disc);
         vx = b;
         vy = $signed(d - a + $signed(r));
         vy = $signed(vy[63:0]);
         vy = vy / 2;
         dot = sx * vx + sy * vy;
         if (dot < 0) begin
            vx = -vx; vy = -vy;
         end
         e.dx = clip48(vx);
         e.dy = clip48(vy);
         e.ok = 1'b1;
      end
      expected_dirs.insert(expected_dirs.size(), e);
      pt_count = 0; sum_x = '0; sum_y = '0; sq_x = '0; sq_y = '0; cr_sum = '0;
   endtask

   task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                  input logic [OUT_BITS-1:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord(input int spread);
      case ($urandom_range(0, 9))
         0: return {1'b0, {(COORD_BITS-1){1'b1}}};
         1: return {1'b1, {(COORD_BITS-1){1'b0}}};
         2, 3: return COORD_BITS'($urandom);
         default: return COORD_BITS'($signed($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   task automatic add_set(input int len, input bit with_first, input int spread);
      point_type p;
      logic signed [COORD_BITS-1:0] cx, cy;
      cx = rand_coord(spread); cy = rand_coord(spread);
      for (int i = 0; i < len; i++) begin
         p.cx = (i == 0) ? cx : COORD_BITS'($urandom);
         p.cy = (i == 0) ? cy : COORD_BITS'($urandom);
         p.px = COORD_BITS'(cx + rand_coord(spread));
         p.py = COORD_BITS'(cy + rand_coord(spread));
         p.first = with_first && (i == 0);
         p.last = (i == len - 1);
         append_point(p);
      end
   endtask

   // directed part
   task automatic add_directed();
      point_type p;
      localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
      localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
      // single point set: first and last together
      p = '{px: 5, py: -3, cx: 1, cy: 2, first: 1, last: 1};
      append_point(p);
      // extremes around an extreme centre
      p = '{px: CMAX, py: CMIN, cx: CMIN, cy: CMAX, first: 1, last: 0};
      append_point(p);
      p = '{px: CMIN, py: CMAX, cx: 0, cy: 0, first: 0, last: 0};
      append_point(p);
      p = '{px: CMAX, py: CMAX, cx: 0, cy: 0, first: 0, last: 1};
      append_point(p);
      // identical points: degenerate matrix
      p = '{px: 7, py: 7, cx: 0, cy: 0, first: 1, last: 0};
      append_point(p);
      p = '{px: 7, py: 7, cx: 0, cy: 0, first: 0, last: 1};
      append_point(p);
      // held centre reused without first
      p = '{px: 100, py: 0, cx: 0, cy: 0, first: 0, last: 0};
      append_point(p);
      p = '{px: -50, py: 0, cx: 0, cy: 0, first: 0, last: 1};
      append_point(p);
      // vertical line, vector against the mean offset
      p = '{px: 0, py: -10, cx: 0, cy: 0, first: 1, last: 0};
      append_point(p);
      p = '{px: 0, py: -90, cx: 0, cy: 0, first: 0, last: 1};
      append_point(p);
      // diagonal
      p = '{px: 3, py: 3, cx: 0, cy: 0, first: 1, last: 0};
      append_point(p);
      p = '{px: -4, py: -4, cx: 0, cy: 0, first: 0, last: 1};
      append_point(p);
      // last point alone with no set open
      p = '{px: 9, py: 9, cx: 0, cy: 0, first: 0, last: 1};
      append_point(p);
   endtask

   initial begin
      int total;
      int len;
      stim_done = 1'b0;
      ctr_x = '0; ctr_y = '0;
      pt_count = 0; sum_x = '0; sum_y = '0; sq_x = '0; sq_y = '0; cr_sum = '0;
      add_directed();
      // one set past the point cap
      add_set(POINT_CAP + 10, 1'b1, 4000);
      total = pending_points.size();
      while (total < 1600) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
         add_set(len, $urandom_range(0, 7) != 0, ($urandom_range(0, 3) == 0) ? 131071 : 2000);
         total += len;
      end
   end

   // driver
   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold
      end else begin
         if (req_ch.valid) predict_direction(pending_points.pop_front());
         if (send_gap > 0 || pending_points.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
            if (pending_points.size() == 0) stim_done <= 1'b1;
         end else begin
            p = pending_points[0];
            req_ch.valid <= 1'b1;
            req_ch.point_x <= p.px;
            req_ch.point_y <= p.py;
            req_ch.center_x <= p.cx;
            req_ch.center_y <= p.cy;
            req_ch.first_point <= p.first;
            req_ch.last_point <= p.last;
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      dir_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_dirs.size() == 0) begin
               report_mismatch("unexpected item", '0, '0);
            end else begin
               e = expected_dirs.pop_front();
               if (rsp_ch.dir_x !== e.dx) report_mismatch("dir_x", rsp_ch.dir_x, e.dx);
               if (rsp_ch.dir_y !== e.dy) report_mismatch("dir_y", rsp_ch.dir_y, e.dy);
               if (rsp_ch.valid_res !== e.ok)
                  report_mismatch("valid_res", rsp_ch.valid_res, e.ok);
            end
            rsp_ch.ready <= 1'b0;
            recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
         end else if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off once, early in the random part
   always @(posedge clock) begin
      if (reset) begin
         hold_off  <= 0;
         rsp_seen  <= 0;
         hold_used <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) rsp_seen <= rsp_seen + 1;
         if (!hold_used && rsp_seen == 12) begin
            hold_off  <= 3000;
            hold_used <= 1'b1;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.first_point = 1'b0;
      req_ch.last_point = 1'b0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && expected_dirs.size() == 0);
            repeat (800) @(posedge clock);
            if (error_count == 0 && expected_dirs.size() == 0)
               $display("ALL CHECKS PASSED");
            else
               $display("CHECKS FAILED");
         end
         begin
            wait (idle_cycles >= STALL_LIMIT);
            $display("timeout");
            $display("CHECKS FAILED");
         end
      join_any
      $finish;
   end
endmodule
